// File: rtl/bgpe_pkg.sv
`default_nettype none
package bgpe_pkg;

  localparam int unsigned GlyphSize = 8;
  localparam int unsigned RowW      = 3;
  localparam int unsigned AddrW     = 26;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned DimW      = 13;
  localparam int unsigned PitchW    = 16;
  localparam int unsigned WordsW    = 14;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [7:0] FirstCode = 8'd32;

  localparam logic [DimW-1:0]   ResetWidth  = 13'd1024;
  localparam logic [DimW-1:0]   ResetHeight = 13'd768;
  localparam logic [PitchW-1:0] ResetPitch  = 16'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_LINE_PITCH    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_DRAW = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic [ColorW-1:0]        ink_color;
  } draw_t;

  typedef struct packed {
    logic [DimW-1:0]   screen_width;
    logic [DimW-1:0]   screen_height;
    logic [PitchW-1:0] line_pitch_bytes;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/bgpe_ram.sv
`default_nettype none
module bgpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/bgpe_expander.sv
`default_nettype none
module bgpe_expander #(
  parameter int unsigned GlyphW = 7
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [GlyphW-1:0]                   glyph_i,
  input  wire bgpe_pkg::draw_t                     draw_i,
  input  wire bgpe_pkg::cfg_t                      cfg_i,
  output logic                                     busy_o,
  output logic                                     rd_en_o,
  output logic [GlyphW+bgpe_pkg::RowW-1:0]         rd_addr_o,
  input  wire logic [bgpe_pkg::GlyphSize-1:0]      rd_data_i,
  output logic                                     m_valid_o,
  input  wire logic                                m_ready_i,
  output logic [bgpe_pkg::AddrW-1:0]               m_addr_o,
  output logic [bgpe_pkg::ColorW-1:0]              m_color_o,
  output logic                                     m_last_o
);

  localparam int unsigned RowW   = bgpe_pkg::RowW;
  localparam int unsigned CoordW = bgpe_pkg::CoordW;
  localparam int unsigned DimW   = bgpe_pkg::DimW;
  localparam int unsigned WordsW = bgpe_pkg::WordsW;
  localparam int unsigned AddrW  = bgpe_pkg::AddrW;
  localparam int unsigned ColorW = bgpe_pkg::ColorW;

  bgpe_pkg::state_e state_q, state_d;
  logic [GlyphW-1:0] glyph_q, glyph_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [RowW-1:0]   col_q, col_d;
  bgpe_pkg::draw_t   draw_q, draw_d;

  logic              hold_valid_q, hold_valid_d;
  logic [AddrW-1:0]  hold_addr_q, hold_addr_d;

  logic              out_valid_q, out_valid_d;
  logic [AddrW-1:0]  out_addr_q, out_addr_d;
  logic [ColorW-1:0] out_color_q, out_color_d;
  logic              out_last_q, out_last_d;

  logic [CoordW:0]         px, py;
  logic                    bit_set, x_ok, y_ok, hit, out_free, advance;
  logic [WordsW-1:0]       words;
  logic [DimW+WordsW-1:0]  prod;
  logic [AddrW-1:0]        pix_addr;

  assign words    = cfg_i.line_pitch_bytes[bgpe_pkg::PitchW-1:2];
  assign px       = {draw_q.origin_x[CoordW-1], draw_q.origin_x} + (CoordW+1)'(col_q);
  assign py       = {draw_q.origin_y[CoordW-1], draw_q.origin_y} + (CoordW+1)'(row_q);
  assign bit_set  = rd_data_i[3'd7 - col_q];
  assign x_ok     = !px[CoordW] && (px[CoordW-1:0] < CoordW'(cfg_i.screen_width));
  assign y_ok     = !py[CoordW] && (py[CoordW-1:0] < CoordW'(cfg_i.screen_height));
  assign hit      = (state_q == bgpe_pkg::ST_SCAN) && bit_set && x_ok && y_ok;
  assign prod     = py[DimW-1:0] * words;
  assign pix_addr = AddrW'(prod + (DimW+WordsW)'(px[DimW-1:0]));
  assign out_free = !out_valid_q || m_ready_i;
  assign advance  = !(hit && hold_valid_q) || out_free;

  always_comb begin
    state_d      = state_q;
    glyph_d      = glyph_q;
    row_d        = row_q;
    col_d        = col_q;
    draw_d       = draw_q;
    hold_valid_d = hold_valid_q;
    hold_addr_d  = hold_addr_q;
    out_valid_d  = out_valid_q && !m_ready_i;
    out_addr_d   = out_addr_q;
    out_color_d  = out_color_q;
    out_last_d   = out_last_q;
    rd_en_o      = 1'b0;
    rd_addr_o    = {glyph_q, row_q + 3'd1};

    unique case (state_q)
      bgpe_pkg::ST_IDLE: begin
        if (start_i) begin
          rd_en_o   = 1'b1;
          rd_addr_o = {glyph_i, 3'd0};
          glyph_d   = glyph_i;
          draw_d    = draw_i;
          row_d     = '0;
          col_d     = '0;
          state_d   = bgpe_pkg::ST_SCAN;
        end
      end
      bgpe_pkg::ST_SCAN: begin
        if (advance) begin
          if (hit) begin
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              out_addr_d  = hold_addr_q;
              out_color_d = draw_q.ink_color;
              out_last_d  = 1'b0;
            end
            hold_valid_d = 1'b1;
            hold_addr_d  = pix_addr;
          end
          col_d = col_q + 3'd1;
          if (col_q == 3'd7) begin
            row_d = row_q + 3'd1;
            if (row_q == 3'd7) begin
              state_d = bgpe_pkg::ST_FLUSH;
            end else begin
              rd_en_o = 1'b1;
            end
          end
        end
      end
      bgpe_pkg::ST_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = bgpe_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_addr_d   = hold_addr_q;
          out_color_d  = draw_q.ink_color;
          out_last_d   = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = bgpe_pkg::ST_IDLE;
        end
      end
      default: state_d = bgpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bgpe_pkg::ST_IDLE;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q     <= glyph_d;
    row_q       <= row_d;
    col_q       <= col_d;
    draw_q      <= draw_d;
    hold_addr_q <= hold_addr_d;
    out_addr_q  <= out_addr_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign busy_o    = (state_q != bgpe_pkg::ST_IDLE);
  assign m_valid_o = out_valid_q;
  assign m_addr_o  = out_addr_q;
  assign m_color_o = out_color_q;
  assign m_last_o  = out_last_q;

endmodule
`default_nettype wire

// File: rtl/bitmap_glyph_pixel_expander.sv
// Load transfer: the row is written to the font RAM at the accepting edge.
// Draw transfer: a scan state over the glyph positions (one font RAM read per row), then a
// flush state; no new item is accepted until the expander is idle again.
// A pixel write waits until the next visible set bit or the flush, then is offered
// from the output register in the following cycle; at most one pixel write per cycle.
// Reset: control state cleared, default screen size and pitch; font RAM undefined until loaded.
`default_nettype none
module bitmap_glyph_pixel_expander #(
  parameter int unsigned GLYPH_COUNT = 96
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [bgpe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                  cfg_data_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // char_code, glyph_row, row_bits, origin_x, origin_y, ink_color, zero pad
  input  wire logic [87:0]                  s_axis_tdata,
  // action
  input  wire logic                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // word_address, pixel_value, zero pad
  output logic [63:0]                       m_axis_tdata,
  // last_write
  output logic                              m_axis_tlast
);

  localparam int unsigned GlyphW = $clog2(GLYPH_COUNT);
  localparam int unsigned Depth  = GLYPH_COUNT * bgpe_pkg::GlyphSize;
  localparam int unsigned RamAw  = GlyphW + bgpe_pkg::RowW;

  bgpe_pkg::cfg_t cfg_q, cfg_d;

  logic [7:0]  char_code;
  logic [2:0]  glyph_row;
  logic [7:0]  row_bits;
  logic [8:0]  code_off;
  logic        code_ok, accept, busy;
  logic        load_we, draw_start;
  logic [GlyphW-1:0] glyph;
  bgpe_pkg::draw_t   draw;

  logic              rd_en;
  logic [RamAw-1:0]  rd_addr;
  logic [7:0]        rd_data;

  logic [bgpe_pkg::AddrW-1:0]  out_addr;
  logic [bgpe_pkg::ColorW-1:0] out_color;

  assign char_code      = s_axis_tdata[7:0];
  assign glyph_row      = s_axis_tdata[10:8];
  assign row_bits       = s_axis_tdata[18:11];
  assign draw.origin_x  = s_axis_tdata[34:19];
  assign draw.origin_y  = s_axis_tdata[50:35];
  assign draw.ink_color = s_axis_tdata[82:51];

  assign code_off = {1'b0, char_code} - {1'b0, bgpe_pkg::FirstCode};
  assign code_ok  = (char_code >= bgpe_pkg::FirstCode) && (code_off < 9'(GLYPH_COUNT));
  assign glyph    = code_off[GlyphW-1:0];

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_we       = accept && code_ok && (s_axis_tuser == bgpe_pkg::ACT_LOAD);
  assign draw_start    = accept && code_ok && (s_axis_tuser == bgpe_pkg::ACT_DRAW);

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bgpe_pkg::CFG_SCREEN_WIDTH:  cfg_d.screen_width     = cfg_data_i[bgpe_pkg::DimW-1:0];
        bgpe_pkg::CFG_SCREEN_HEIGHT: cfg_d.screen_height    = cfg_data_i[bgpe_pkg::DimW-1:0];
        bgpe_pkg::CFG_LINE_PITCH:    cfg_d.line_pitch_bytes = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width     <= bgpe_pkg::ResetWidth;
      cfg_q.screen_height    <= bgpe_pkg::ResetHeight;
      cfg_q.line_pitch_bytes <= bgpe_pkg::ResetPitch;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bgpe_ram #(
    .Width (bgpe_pkg::GlyphSize),
    .Depth (Depth)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i ({glyph, glyph_row}),
    .wdata_i (row_bits),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  bgpe_expander #(
    .GlyphW (GlyphW)
  ) u_expander (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (draw_start),
    .glyph_i   (glyph),
    .draw_i    (draw),
    .cfg_i     (cfg_q),
    .busy_o    (busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_addr_o  (out_addr),
    .m_color_o (out_color),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_color, out_addr};

endmodule
`default_nettype wire

// File: test/bgpe_pixel_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module bgpe_pixel_checker #(
  parameter int unsigned GLYPH_COUNT = 96
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic                         cfg_ready_i,
  input  wire logic [bgpe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                  cfg_data_i,
  input  wire logic                         s_tvalid_i,
  input  wire logic                         s_tready_i,
  input  wire logic [87:0]                  s_tdata_i,
  input  wire logic                         s_tuser_i,
  input  wire logic                         m_tvalid_i,
  input  wire logic                         m_tready_i,
  input  wire logic [63:0]                  m_tdata_i,
  input  wire logic                         m_tlast_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);

  typedef struct packed {
    logic [bgpe_pkg::AddrW-1:0]  word_address;
    logic [bgpe_pkg::ColorW-1:0] pixel_value;
    logic                        last_write;
  } pixel_write_t;

  logic [7:0]     glyph_rows [GLYPH_COUNT*bgpe_pkg::GlyphSize];
  bgpe_pkg::cfg_t screen;
  pixel_write_t   pending_writes [$];
  int             mismatches = 0;
  int             writes_seen = 0;

  // updates the font copy on a load, queues the clipped pixel writes on a draw
  function automatic void expand_glyph(bgpe_pkg::action_e act, logic [87:0] d);
    logic [7:0]   code;
    int unsigned  base;
    int unsigned  words;
    int           py;
    int           px;
    int           first;
    logic [7:0]   pat;
    logic [31:0]  addr;
    pixel_write_t w;
    code = d[7:0];
    if (code < bgpe_pkg::FirstCode || code >= bgpe_pkg::FirstCode + GLYPH_COUNT) return;
    base = (code - bgpe_pkg::FirstCode) * bgpe_pkg::GlyphSize;
    if (act == bgpe_pkg::ACT_LOAD) begin
      glyph_rows[base + d[10:8]] = d[18:11];
      return;
    end
    words = screen.line_pitch_bytes / 4;
    first = pending_writes.size();
    for (int row = 0; row < bgpe_pkg::GlyphSize; row++) begin
      py = $signed(d[50:35]) + row;
      if (py < 0 || py >= int'(screen.screen_height)) continue;
      pat = glyph_rows[base + row];
      for (int col = 0; col < bgpe_pkg::GlyphSize; col++) begin
        px = $signed(d[34:19]) + col;
        if ((pat & (8'h80 >> col)) == 8'h00) continue;
        if (px < 0 || px >= int'(screen.screen_width)) continue;
        addr = py * words + px;
        w.word_address = addr[bgpe_pkg::AddrW-1:0];
        w.pixel_value  = d[82:51];
        w.last_write   = 1'b0;
        pending_writes.push_back(w);
      end
    end
    if (pending_writes.size() > first)
      pending_writes[pending_writes.size()-1].last_write = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_write_t want;
    if (!rst_ni) begin
      screen.screen_width     = bgpe_pkg::ResetWidth;
      screen.screen_height    = bgpe_pkg::ResetHeight;
      screen.line_pitch_bytes = bgpe_pkg::ResetPitch;
      pending_writes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (bgpe_pkg::cfg_idx_e'(cfg_index_i))
          bgpe_pkg::CFG_SCREEN_WIDTH:
            screen.screen_width     = cfg_data_i[bgpe_pkg::DimW-1:0];
          bgpe_pkg::CFG_SCREEN_HEIGHT:
            screen.screen_height    = cfg_data_i[bgpe_pkg::DimW-1:0];
          bgpe_pkg::CFG_LINE_PITCH:
            screen.line_pitch_bytes = cfg_data_i[bgpe_pkg::PitchW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) expand_glyph(bgpe_pkg::action_e'(s_tuser_i), s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        writes_seen++;
        if (pending_writes.size() == 0) begin
          $error("unexpected pixel write: word_address %h pixel_value %h last_write %b",
                 m_tdata_i[25:0], m_tdata_i[57:26], m_tlast_i);
          mismatches++;
        end else begin
          want = pending_writes.pop_front();
          if (m_tdata_i[25:0] !== want.word_address) begin
            $error("word_address: expected %h, got %h", want.word_address, m_tdata_i[25:0]);
            mismatches++;
          end
          if (m_tdata_i[57:26] !== want.pixel_value) begin
            $error("pixel_value: expected %h, got %h", want.pixel_value, m_tdata_i[57:26]);
            mismatches++;
          end
          if (m_tlast_i !== want.last_write) begin
            $error("last_write: expected %b, got %b", want.last_write, m_tlast_i);
            mismatches++;
          end
        end
      end
    end
    pending_o    <= pending_writes.size();
    fail_count_o <= mismatches;
    checked_o    <= writes_seen;
  end

endmodule
`default_nettype wire

// File: test/bitmap_glyph_pixel_expander_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module bitmap_glyph_pixel_expander_tb;

  localparam int unsigned GlyphCount  = 96;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned HoldCycles  = 400;
  localparam logic [7:0]  LastCode    = 8'(bgpe_pkg::FirstCode + GlyphCount - 1);
  localparam logic [7:0]  PastCode    = 8'(bgpe_pkg::FirstCode + GlyphCount);
  localparam logic [7:0]  BelowCode   = bgpe_pkg::FirstCode - 8'd1;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic [bgpe_pkg::CfgIdxW-1:0] cfg_index_i   = '0;
  logic [15:0]                  cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic [87:0]                  s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         m_axis_tready = 1'b0;
  wire logic                    cfg_ready_o;
  wire logic                    s_axis_tready;
  wire logic                    m_axis_tvalid;
  wire logic [63:0]             m_axis_tdata;
  wire logic                    m_axis_tlast;

  int          fail_count;
  int          writes_pending;
  int          writes_checked;
  int          cycle_count = 0;
  int          items_sent  = 0;
  int          draws_sent  = 0;
  int          hold_left   = 0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_taken  = 1'b0;
  int unsigned cur_w       = 32'(bgpe_pkg::ResetWidth);
  int unsigned cur_h       = 32'(bgpe_pkg::ResetHeight);
  logic [7:0]  rows_loaded [256];

  bitmap_glyph_pixel_expander #(.GLYPH_COUNT(GlyphCount)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  bgpe_pixel_checker #(.GLYPH_COUNT(GlyphCount)) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (writes_pending),
    .checked_o    (writes_checked)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("bitmap_glyph_pixel_expander test failed");
      $finish;
    end
  end

  // pixel write sink; one long hold-off on request to back up the pipeline
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 28);
    end
  end

  function automatic logic [87:0] pack_item(logic [7:0] code, logic [2:0] row,
                                            logic [7:0] bits, logic [15:0] ox,
                                            logic [15:0] oy, logic [31:0] ink);
    return {5'b0, ink, oy, ox, bits, row, code};
  endfunction

  function automatic bit code_in_font(logic [7:0] code);
    return code >= bgpe_pkg::FirstCode && code < bgpe_pkg::FirstCode + GlyphCount;
  endfunction

  function automatic logic [7:0] pick_loaded_code();
    logic [7:0] c;
    do c = 8'($urandom_range(LastCode, bgpe_pkg::FirstCode));
    while (rows_loaded[c] != 8'hFF);
    return c;
  endfunction

  function automatic logic [15:0] near_coord(int unsigned extent);
    int v;
    v = int'($urandom_range(extent + 9)) - 8;
    return v[15:0];
  endfunction

  task automatic send_item(bgpe_pkg::action_e act, logic [87:0] d);
    if (!calm) begin
      while ($urandom_range(99) < 28) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (code_in_font(d[7:0])) begin
      items_sent++;
      if (act == bgpe_pkg::ACT_LOAD) rows_loaded[d[7:0]][d[10:8]] = 1'b1;
      else draws_sent++;
    end
  endtask

  task automatic load_glyph(logic [7:0] code, logic [63:0] rows);
    for (int r = 0; r < bgpe_pkg::GlyphSize; r++)
      send_item(bgpe_pkg::ACT_LOAD, pack_item(code, r[2:0], rows[63-8*r -: 8],
                                              16'($urandom), 16'($urandom), $urandom));
  endtask

  task automatic draw_glyph(logic [7:0] code, logic [15:0] ox, logic [15:0] oy,
                            logic [31:0] ink);
    send_item(bgpe_pkg::ACT_DRAW, pack_item(code, 3'($urandom_range(7)),
                                            8'($urandom_range(255)), ox, oy, ink));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (writes_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_transfer(bgpe_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_screen(logic [15:0] w, logic [15:0] h, logic [15:0] pitch);
    settle();
    cfg_transfer(bgpe_pkg::CFG_SCREEN_WIDTH, w);
    cfg_transfer(bgpe_pkg::CFG_SCREEN_HEIGHT, h);
    cfg_transfer(bgpe_pkg::CFG_LINE_PITCH, pitch);
    cfg_valid_i <= 1'b0;
    cur_w = 32'(w);
    cur_h = 32'(h);
  endtask

  task automatic random_items(int count);
    int          stop_at;
    int unsigned r;
    logic [7:0]  code;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 12) begin
        load_glyph(8'($urandom_range(LastCode, bgpe_pkg::FirstCode)), {$urandom, $urandom});
      end else if (r < 20) begin
        send_item(bgpe_pkg::ACT_LOAD,
                  pack_item(8'($urandom_range(255)), 3'($urandom_range(7)),
                            8'($urandom_range(255)), 16'($urandom), 16'($urandom),
                            $urandom));
      end else if (r < 28) begin
        code = 8'($urandom_range(255));
        if (code_in_font(code) && rows_loaded[code] != 8'hFF) code = pick_loaded_code();
        draw_glyph(code, near_coord(cur_w), near_coord(cur_h), $urandom);
      end else if (r < 36) begin
        draw_glyph(pick_loaded_code(), 16'($urandom), 16'($urandom), $urandom);
      end else begin
        draw_glyph(pick_loaded_code(), near_coord(cur_w), near_coord(cur_h), $urandom);
      end
    end
  endtask

  initial begin
    for (int c = 0; c < 256; c++) rows_loaded[c] = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lowest and highest codes, edge patterns, clipping on every side
    load_glyph(bgpe_pkg::FirstCode, 64'hFF80_0181_3C00_AA55);
    load_glyph(LastCode, {8{8'hFF}});
    draw_glyph(bgpe_pkg::FirstCode, 16'd0, 16'd0, 32'hFFFF_FFFF);
    draw_glyph(LastCode, 16'd1020, 16'd764, 32'h0000_0000);
    draw_glyph(LastCode, -16'sd4, -16'sd4, 32'hA5A5_A5A5);
    draw_glyph(LastCode, 16'h8000, 16'h8000, 32'h1234_5678);
    draw_glyph(LastCode, 16'h7FFF, 16'h7FFF, 32'h8765_4321);
    draw_glyph(bgpe_pkg::FirstCode, 16'd1023, 16'd0, 32'h5A5A_5A5A);
    draw_glyph(BelowCode, 16'd0, 16'd0, 32'hDEAD_BEEF);
    draw_glyph(PastCode, 16'd0, 16'd0, 32'hDEAD_BEEF);
    draw_glyph(8'd255, 16'd8, 16'd8, 32'hCAFE_F00D);
    send_item(bgpe_pkg::ACT_LOAD, pack_item(8'd200, 3'd3, 8'hFF, 16'd0, 16'd0, 32'd0));

    set_screen(16'd4096, 16'd4096, 16'hFFFF);
    calm = 1'b1;
    random_items(30);

    set_screen(16'd40, 16'd24, 16'd160);
    calm     = 1'b0;
    hold_req <= 1'b1;
    random_items(30);

    set_screen(16'd0, 16'd768, 16'd4096);
    random_items(10);
    set_screen(16'd1024, 16'd0, 16'd4096);
    random_items(10);

    set_screen(16'd4095, 16'd4095, 16'd0);
    random_items(8);
    set_screen(16'd8, 16'd2, 16'd3);
    random_items(8);

    set_screen(16'($urandom_range(4096, 1)), 16'($urandom_range(4096, 1)),
               16'($urandom_range(65535)));
    random_items(30);

    settle();
    $display("%0d font items sent (%0d draws), %0d pixel writes checked",
             items_sent, draws_sent, writes_checked);
    $display("screens from zero size to 4096x4096, pitches 0 to 65535, one long output stall");
    if (fail_count == 0) begin
      $display("bitmap_glyph_pixel_expander test passed");
    end else begin
      $display("bitmap_glyph_pixel_expander test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: bitmap_glyph_pixel_expander.f
rtl/bgpe_pkg.sv
rtl/bgpe_ram.sv
rtl/bgpe_expander.sv
rtl/bitmap_glyph_pixel_expander.sv
test/bgpe_pixel_checker.sv
test/bitmap_glyph_pixel_expander_tb.sv
